FILE: hdl/transport_stream_packetizer_core_macros.svh
// Assertion macros, clocked on i_clk and disabled while i_rst_n is low.
`ifndef TRANSPORT_STREAM_PACKETIZER_CORE_MACROS_SVH
`define TRANSPORT_STREAM_PACKETIZER_CORE_MACROS_SVH

// Same-cycle implication.
`define TSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

    localparam int PID_W   = 13;
    localparam int PCR_W   = 33;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int CC_W    = 4;
    localparam int FILL_W  = 8;
    localparam int POS_W   = 8;
    localparam int FRAME_W = 9;

    localparam int PID_ENTRIES_DEF = 8192;
    localparam int PAYLOAD_DEPTH   = 182;

    localparam logic [FRAME_W-1:0] PKT_BYTES       = 9'd188;
    localparam logic [POS_W-1:0]   LAST_POS        = 8'd187;
    localparam logic [BYTE_W-1:0]  AF_LEN_MAX      = 8'd183;
    localparam logic [FILL_W-1:0]  MAX_PAYLOAD     = 8'd182;
    localparam logic [FILL_W-1:0]  MAX_PAYLOAD_PCR = 8'd176;

    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h47;
    localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'hFF;
    localparam logic [PID_W-1:0]  NULL_PID   = 13'h1FFF;
    localparam logic [PID_W-1:0]  PCR_PID_RST = 13'd256;

    localparam logic ACT_PAYLOAD = 1'b0;
    localparam logic ACT_NULL    = 1'b1;

    typedef struct packed {
        logic              action;
        logic [PID_W-1:0]  pid;
        logic [BYTE_W-1:0] payload_byte;
        logic              unit_start;
        logic              unit_end;
        logic [PCR_W-1:0]  pcr_base;
    } t_ts_in;

    typedef struct packed {
        logic [WORD_W-1:0] ts_word;
        logic              last_word;
    } t_ts_out;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic              pusi;
        logic              with_pcr;
        logic [FILL_W-1:0] n;
        logic [PCR_W-1:0]  pcr_base;
    } t_pkt_ctx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_READ,
        ST_LAUNCH,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/tsp_ram.sv
`default_nettype none

module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/tsp_emit.sv
`default_nettype none

module tsp_emit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire tsp_pkg::t_pkt_ctx            i_ctx,
    input  wire logic [tsp_pkg::CC_W-1:0]     i_cc,
    output logic                              o_busy,
    output logic                              o_rd_en,
    output logic      [tsp_pkg::FILL_W-1:0]   o_rd_addr,
    input  wire logic [tsp_pkg::BYTE_W-1:0]   i_rd_data,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output tsp_pkg::t_ts_out                  o_out
);

    import tsp_pkg::*;

    logic                  r_a_valid;
    logic                  n_a_valid;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      n_pos;

    logic                  r_b_valid;
    logic                  r_b_mem;
    logic [BYTE_W-1:0]     r_b_byte;
    logic                  r_b_wend;
    logic                  r_b_last;

    logic [3*BYTE_W-1:0]   r_acc;
    logic                  r_out_valid;
    t_ts_out               r_out;

    logic                  w_en;
    logic                  w_mem;
    logic [BYTE_W-1:0]     w_byte;
    logic [BYTE_W-1:0]     w_b_data;
    logic [FRAME_W-1:0]    w_pos9;
    logic [FRAME_W-1:0]    w_n9;
    logic [FRAME_W-1:0]    w_pay_start;
    logic [FRAME_W-1:0]    w_rd_full;
    logic [PCR_W-1:0]      w_b;

    assign w_en        = !r_out_valid || !i_stall;
    assign w_pos9      = {1'b0, r_pos};
    assign w_n9        = {1'b0, i_ctx.n};
    assign w_pay_start = PKT_BYTES - w_n9;
    assign w_rd_full   = w_pos9 + w_n9 - PKT_BYTES;
    assign w_b         = i_ctx.pcr_base;

    always_comb begin
        w_mem  = (w_pos9 >= w_pay_start);
        w_byte = STUFF_BYTE;
        case (r_pos)
            8'd0: begin
                w_mem  = 1'b0;
                w_byte = SYNC_BYTE;
            end
            8'd1: begin
                w_mem  = 1'b0;
                w_byte = {1'b0, i_ctx.pusi, 1'b0, i_ctx.pid[PID_W-1:8]};
            end
            8'd2: begin
                w_mem  = 1'b0;
                w_byte = i_ctx.pid[7:0];
            end
            8'd3: begin
                w_mem  = 1'b0;
                w_byte = {2'b00, 1'b1, (i_ctx.n != '0), i_cc};
            end
            8'd4: begin
                w_mem  = 1'b0;
                w_byte = AF_LEN_MAX - i_ctx.n;
            end
            8'd5: begin
                w_mem  = 1'b0;
                w_byte = {1'b0, 1'b1, 1'b0, i_ctx.with_pcr, 4'b0000};
            end
            8'd6: begin
                if (i_ctx.with_pcr) begin
                    w_mem  = 1'b0;
                    w_byte = w_b[32:25];
                end
            end
            8'd7: begin
                if (i_ctx.with_pcr) begin
                    w_mem  = 1'b0;
                    w_byte = w_b[24:17];
                end
            end
            8'd8: begin
                if (i_ctx.with_pcr) begin
                    w_mem  = 1'b0;
                    w_byte = w_b[16:9];
                end
            end
            8'd9: begin
                if (i_ctx.with_pcr) begin
                    w_mem  = 1'b0;
                    w_byte = w_b[8:1];
                end
            end
            8'd10: begin
                if (i_ctx.with_pcr) begin
                    w_mem  = 1'b0;
                    w_byte = {w_b[0], 7'h7E};
                end
            end
            8'd11: begin
                if (i_ctx.with_pcr) begin
                    w_mem  = 1'b0;
                    w_byte = 8'h00;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_a_valid = r_a_valid;
        n_pos     = r_pos;
        if (i_start) begin
            n_a_valid = 1'b1;
            n_pos     = '0;
        end else if (w_en && r_a_valid) begin
            if (r_pos == LAST_POS) begin
                n_a_valid = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    assign o_rd_en   = w_en && r_a_valid && w_mem;
    assign o_rd_addr = w_rd_full[FILL_W-1:0];
    assign w_b_data  = r_b_mem ? i_rd_data : r_b_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            if (w_en) begin
                r_b_valid <= r_a_valid;
            end
            if (w_en && r_b_valid && r_b_wend) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (w_en) begin
            r_b_mem  <= w_mem;
            r_b_byte <= w_byte;
            r_b_wend <= (r_pos[1:0] == 2'b11);
            r_b_last <= (r_pos == LAST_POS);
            if (r_b_valid) begin
                if (r_b_wend) begin
                    r_out.ts_word   <= {r_acc, w_b_data};
                    r_out.last_word <= r_b_last;
                end else begin
                    r_acc <= {r_acc[2*BYTE_W-1:0], w_b_data};
                end
            end
        end
    end

    assign o_busy  = r_a_valid || r_b_valid;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

FILE: hdl/transport_stream_packetizer_core.sv
// Transport stream packetizer: frames unit payload bytes into 188-byte transport packets,
// sent as 47 big-endian words with last_word on the 47th. A byte that completes no packet
// is taken without stalling the input. A byte that completes a packet, or a null request,
// stalls the input through the launch states QUOT, READ and LAUNCH (PID index reduction
// and the continuity RAM read-modify-write) and then while the framer walks the packet one
// byte per cycle when the output is not stalled, reading held payload from the simple
// dual-port payload RAM; the input reopens once the last byte is framed, while the last word
// may still drain. After reset a clearing pass writes zero to every continuity RAM entry,
// during which no item is accepted. Write pcr_pid only while the block is idle.
`default_nettype none

`include "transport_stream_packetizer_core_macros.svh"

module transport_stream_packetizer_core #(
    parameter int PID_ENTRIES = tsp_pkg::PID_ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire tsp_pkg::t_ts_in             i_in,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output tsp_pkg::t_ts_out                 o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [tsp_pkg::PID_W-1:0]   i_cfg_data
);

    import tsp_pkg::*;

    localparam int IW = $clog2(PID_ENTRIES);
    localparam int QS = 26;
    localparam int RW = QS + 1;
    localparam int PW = PID_W + RW;
    localparam int EW = PID_W + 1;
    localparam int DW = PID_W + EW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << QS) + 64'(PID_ENTRIES) - 64'd1) / 64'(PID_ENTRIES));
    localparam logic [EW-1:0] ENT      = EW'(PID_ENTRIES);
    localparam logic [IW-1:0] CLR_LAST = IW'(PID_ENTRIES - 1);

    t_state            r_state;
    t_state            n_state;
    logic [IW-1:0]     r_clr;
    logic [IW-1:0]     n_clr;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [PID_W-1:0]  r_cur_pid;
    logic [PID_W-1:0]  n_cur_pid;
    logic              r_start_pending;
    logic              n_start_pending;
    logic [PID_W-1:0]  r_pcr_pid;
    logic [PID_W-1:0]  n_pcr_pid;
    t_pkt_ctx          r_ctx;
    t_pkt_ctx          n_ctx;
    logic [PID_W-1:0]  r_quot;
    logic [PID_W-1:0]  n_quot;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;

    logic [PW-1:0]     w_prod;
    logic [DW-1:0]     w_qd;
    logic [EW-1:0]     w_rem;
    logic [EW-1:0]     w_rem_fix;
    logic [IW-1:0]     w_idx;

    logic [PID_W-1:0]  w_cur_pid;
    logic [FILL_W-1:0] w_fill0;
    logic [FILL_W-1:0] w_fill1;
    logic              w_room;
    logic              w_sp;
    logic              w_on_pcr;
    logic              w_done;

    logic              w_cc_we;
    logic [IW-1:0]     w_cc_waddr;
    logic [CC_W-1:0]   w_cc_wdata;
    logic              w_cc_re;
    logic [CC_W-1:0]   w_cc_rdata;

    logic              w_pay_we;
    logic              w_pay_re;
    logic [FILL_W-1:0] w_pay_raddr;
    logic [BYTE_W-1:0] w_pay_rdata;

    logic              w_start;
    logic              w_busy;

    assign w_prod    = PW'(r_ctx.pid) * PW'(RECIP);
    assign w_qd      = DW'(r_quot) * DW'(ENT);
    assign w_rem     = {1'b0, r_ctx.pid} - w_qd[EW-1:0];
    assign w_rem_fix = (w_rem >= ENT) ? (w_rem - ENT) : w_rem;
    assign w_idx     = w_rem_fix[IW-1:0];

    assign w_cur_pid = i_in.unit_start ? i_in.pid : r_cur_pid;
    assign w_fill0   = i_in.unit_start ? '0 : r_fill;
    assign w_room    = (w_fill0 < MAX_PAYLOAD);
    assign w_fill1   = w_fill0 + FILL_W'(w_room);
    assign w_sp      = i_in.unit_start || r_start_pending;
    assign w_on_pcr  = (w_cur_pid == r_pcr_pid);
    assign w_done    = (w_on_pcr ? (w_fill1 >= MAX_PAYLOAD_PCR) : (w_fill1 >= MAX_PAYLOAD))
                       || i_in.unit_end;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state         = r_state;
        n_clr           = r_clr;
        n_fill          = r_fill;
        n_cur_pid       = r_cur_pid;
        n_start_pending = r_start_pending;
        n_pcr_pid       = i_cfg_we ? i_cfg_data : r_pcr_pid;
        n_ctx           = r_ctx;
        n_quot          = r_quot;
        n_idx           = r_idx;
        w_cc_we         = 1'b0;
        w_cc_waddr      = r_clr;
        w_cc_wdata      = '0;
        w_cc_re         = 1'b0;
        w_pay_we        = 1'b0;
        w_start         = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_cc_we = 1'b1;
                n_clr   = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_in.action == ACT_NULL) begin
                        n_ctx = '{pid: NULL_PID, pusi: 1'b0,
                                  with_pcr: (r_pcr_pid == NULL_PID),
                                  n: '0, pcr_base: i_in.pcr_base};
                        n_state = ST_QUOT;
                    end else begin
                        w_pay_we  = w_room;
                        n_cur_pid = w_cur_pid;
                        if (w_done) begin
                            n_ctx = '{pid: w_cur_pid, pusi: w_sp,
                                      with_pcr: w_on_pcr && (w_fill1 <= MAX_PAYLOAD_PCR),
                                      n: w_fill1, pcr_base: i_in.pcr_base};
                            n_fill          = '0;
                            n_start_pending = 1'b0;
                            n_state         = ST_QUOT;
                        end else begin
                            n_fill          = w_fill1;
                            n_start_pending = w_sp;
                        end
                    end
                end
            end
            ST_QUOT: begin
                n_quot  = w_prod[QS +: PID_W];
                n_state = ST_READ;
            end
            ST_READ: begin
                w_cc_re = 1'b1;
                n_idx   = w_idx;
                n_state = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                w_cc_we    = (r_ctx.n != '0);
                w_cc_waddr = r_idx;
                w_cc_wdata = w_cc_rdata + 1'b1;
                w_start    = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!w_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr           <= '0;
            r_fill          <= '0;
            r_cur_pid       <= '0;
            r_start_pending <= 1'b0;
            r_pcr_pid       <= PCR_PID_RST;
        end else begin
            r_state         <= n_state;
            r_clr           <= n_clr;
            r_fill          <= n_fill;
            r_cur_pid       <= n_cur_pid;
            r_start_pending <= n_start_pending;
            r_pcr_pid       <= n_pcr_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx  <= n_ctx;
        r_quot <= n_quot;
        r_idx  <= n_idx;
    end

    tsp_ram #(
        .WIDTH (CC_W),
        .DEPTH (PID_ENTRIES)
    ) u_cc_ram (
        .i_clk   (i_clk),
        .i_we    (w_cc_we),
        .i_waddr (w_cc_waddr),
        .i_wdata (w_cc_wdata),
        .i_re    (w_cc_re),
        .i_raddr (w_idx),
        .o_rdata (w_cc_rdata)
    );

    tsp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (w_pay_we),
        .i_waddr (w_fill0),
        .i_wdata (i_in.payload_byte),
        .i_re    (w_pay_re),
        .i_raddr (w_pay_raddr),
        .o_rdata (w_pay_rdata)
    );

    tsp_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_ctx     (r_ctx),
        .i_cc      (w_cc_rdata),
        .o_busy    (w_busy),
        .o_rd_en   (w_pay_re),
        .o_rd_addr (w_pay_raddr),
        .i_rd_data (w_pay_rdata),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out     (o_out)
    );

    `TSP_ASSERT_IMP(a_start_idle, r_state == ST_LAUNCH, !w_busy, "framer started while busy")
    `TSP_ASSERT_NXT(a_launch_busy, r_state == ST_LAUNCH, w_busy, "framer did not start")
    `TSP_ASSERT_IMP(a_pay_quiet, w_pay_we, !w_busy, "payload written during framing")
    `TSP_ASSERT_IMP(a_fill_range, 1'b1, r_fill <= MAX_PAYLOAD, "fill count out of range")

endmodule

`default_nettype wire
